@@ hdl/track_shared_hit_selector_core_assert.svh @@
// Assertion macros for the shared-hit selector core.
// Included by the top level; no other dependencies.
`ifndef TRACK_SHARED_HIT_SELECTOR_CORE_ASSERT_SVH
`define TRACK_SHARED_HIT_SELECTOR_CORE_ASSERT_SVH
`define TSHS_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define TSHS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`endif

@@ hdl/tshs_pkg.sv @@
// Shared types and constants for the shared-hit selector.
// No dependencies.
package tshs_pkg;
   localparam int TRACK_BITS = 6;
   localparam int REF_BITS_IN = 16;
   localparam int QUAL_BITS = 16;
   localparam int LIMIT_BITS = 5;
   localparam int REQ_DATA_BITS = 24;
   localparam int REQ_USER_BITS = QUAL_BITS + 4;
   localparam int RSP_DATA_BITS = 8;
endpackage

@@ hdl/tshs_claim_store.sv @@
// Claimed-hit store with epoch marks: one RAM of epoch numbers.
// Depends on nothing but its parameters.
module tshs_claim_store #(
   parameter int KEY_BITS = 18,
   parameter int EPOCH_BITS = 8
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [KEY_BITS-1:0]   rd_key,
   output logic [EPOCH_BITS-1:0] rd_epoch,
   input  logic                  wr_en,
   input  logic [KEY_BITS-1:0]   wr_key,
   input  logic [EPOCH_BITS-1:0] wr_epoch
);
   logic [EPOCH_BITS-1:0] mem [2**KEY_BITS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_key] <= wr_epoch;
      end
      if (rd_en) begin
         rd_epoch <= mem[rd_key];
      end
   end
endmodule

@@ hdl/track_shared_hit_selector_core.sv @@
// Shared-hit selector core: loads an event's hit beats, sorts its tracks, decides greedily.
// Load: a hit beat is accepted, then the track table is updated; not ready in the update.
// Selection of T tracks: insertion sort, then for each kept track a check pass and a claim
// pass over its hits, a direct result for a bad track, plus result stalls and a clear step.
// Claims carry an 8-bit epoch; every 255th event and every reset start a sweep of the
// whole claim store. Reset: synchronous, active high; not ready during the sweep.
module track_shared_hit_selector_core #(
   parameter int MAX_TRACKS = 64,
   parameter int MAX_HITS_PER_TRACK = 16,
   parameter int REF_ID_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: track_index[5:0], hit_ref_id[21:6], padding zeros
   input  logic [tshs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: is_strip, is_trd, fit_quality[17:2], already_bad, last_hit_of_track
   input  logic [tshs_pkg::REQ_USER_BITS-1:0] req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: out_track_index[5:0], rejected[6], zero
   output logic [tshs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_wr_en,
   input  logic [tshs_pkg::LIMIT_BITS-1:0] csr_wr_data
);
   import tshs_pkg::*;
   `include "track_shared_hit_selector_core_assert.svh"

   localparam int TB = $clog2(MAX_TRACKS);
   localparam int HB = $clog2(MAX_HITS_PER_TRACK + 1);
   localparam int KB = REF_ID_BITS + 2;
   localparam int EB = 8;
   localparam int CB = $clog2(MAX_TRACKS + 1);
   localparam int KEYS_DEPTH = MAX_TRACKS * MAX_HITS_PER_TRACK;
   localparam int KA = $clog2(KEYS_DEPTH);

   typedef enum logic [3:0] {
      ST_SWEEP, ST_LOAD, ST_LD_UPD, ST_SORT_RD, ST_SORT_TRK, ST_SORT_PRV, ST_SORT_CMP,
      ST_PICK_RD, ST_PICK, ST_CHK_RD, ST_CHK_WAIT, ST_CHK, ST_CLAIM_RD, ST_CLAIM, ST_OUT,
      ST_CLEAR
   } state_type;

   // Per-track record kept during load: latest bad mark and quality, stored hit count.
   typedef struct packed {
      logic                 bad;
      logic [QUAL_BITS-1:0] qual;
      logic [HB-1:0]        cnt;
   } track_rec_type;

   // Entry of the sorted list: the track and everything the sort and the walk need.
   typedef struct packed {
      logic [TB-1:0]        track;
      logic                 bad;
      logic [HB-1:0]        cnt;
      logic [QUAL_BITS-1:0] qual;
   } sort_rec_type;

   state_type state_ff;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [MAX_TRACKS-1:0] seen_ff;
   logic [CB-1:0] loaded_ff;
   logic [EB-1:0] epoch_ff;
   logic [KB-1:0] sweep_ff;
   logic [TB-1:0] bt_track_ff;
   logic [KB-1:0] bt_key_ff;
   logic [QUAL_BITS-1:0] bt_qual_ff;
   logic bt_bad_ff, bt_ok_ff, bt_last_ff;
   logic [CB-1:0] i_ff, j_ff, pos_ff;
   logic [TB-1:0] tr_ff;
   logic [HB-1:0] wk_cnt_ff, h_ff, shared_ff;
   logic rej_ff;

   track_rec_type trk_mem [MAX_TRACKS];
   track_rec_type trk_rd_ff;
   logic [TB-1:0] arr_mem [MAX_TRACKS];
   logic [TB-1:0] arr_rd_ff;
   sort_rec_type srt_mem [MAX_TRACKS];
   sort_rec_type srt_rd_ff;
   logic [KB-1:0] keys_mem [KEYS_DEPTH];
   logic [KB-1:0] key_rd_ff;

   logic [KA-1:0] key_addr;
   logic key_rd_en;
   logic [EB-1:0] claim_epoch;
   logic cl_wr_en;
   logic [KB-1:0] cl_wr_key;
   logic [EB-1:0] cl_wr_epoch;

   logic [TB-1:0] in_t;
   logic [KB-1:0] in_key;
   logic in_ok, load_go;
   assign in_t = req_tdata[TB-1:0];
   assign in_ok = ({{(8-TRACK_BITS){1'b0}}, req_tdata[TRACK_BITS-1:0]} < 8'(MAX_TRACKS));
   // Key: TRD bit on top, then the strip bit, then the reference number cut or
   // zero-extended to REF_ID_BITS.
   assign in_key = {req_tuser[1], req_tuser[0],
                    REF_ID_BITS'(req_tdata[TRACK_BITS +: REF_BITS_IN])};
   assign req_tready = (state_ff == ST_LOAD);
   assign load_go = req_tvalid && req_tready;

   // Update cycle of a held beat. A track is new when its seen flag is clear; its
   // stored count then reads as zero whatever the track table holds.
   logic [HB-1:0] upd_cnt;
   logic upd_first, upd_store, upd_on;
   assign upd_on = (state_ff == ST_LD_UPD) && bt_ok_ff;
   assign upd_cnt = seen_ff[bt_track_ff] ? trk_rd_ff.cnt : '0;
   assign upd_first = upd_on && !seen_ff[bt_track_ff] && (loaded_ff < CB'(MAX_TRACKS));
   assign upd_store = upd_on && (upd_cnt < HB'(MAX_HITS_PER_TRACK));

   // Track table: read at the accepting edge of a beat and again while sorting,
   // written back in the update cycle with the beat's quality and bad mark.
   track_rec_type trk_wr_data;
   logic [TB-1:0] trk_raddr;
   logic trk_rd_en;
   assign trk_wr_data = {bt_bad_ff, bt_qual_ff, upd_store ? upd_cnt + HB'(1) : upd_cnt};
   assign trk_raddr = (state_ff == ST_LOAD) ? in_t : arr_rd_ff;
   assign trk_rd_en = (state_ff == ST_LOAD) || (state_ff == ST_SORT_TRK);
   always_ff @(posedge clock) begin
      if (upd_on) begin
         trk_mem[bt_track_ff] <= trk_wr_data;
      end
      if (trk_rd_en) begin
         trk_rd_ff <= trk_mem[trk_raddr];
      end
   end

   // Arrival list: tracks in the order of their first hit.
   always_ff @(posedge clock) begin
      if (upd_first) begin
         arr_mem[TB'(loaded_ff)] <= bt_track_ff;
      end
      if (state_ff == ST_SORT_RD) begin
         arr_rd_ff <= arr_mem[TB'(i_ff)];
      end
   end

   // Sorted list. The track being inserted is compared with entry j-1 of the sorted
   // part; more hits go first, then smaller quality, and equal tracks keep arrival order.
   sort_rec_type cur_rec, srt_wr_data;
   logic cur_ahead, srt_wr_en, srt_rd_en;
   logic [TB-1:0] srt_raddr;
   assign cur_rec = {arr_rd_ff, trk_rd_ff.bad, trk_rd_ff.cnt, trk_rd_ff.qual};
   assign cur_ahead = (cur_rec.cnt != srt_rd_ff.cnt) ? (cur_rec.cnt > srt_rd_ff.cnt)
                    : (cur_rec.qual < srt_rd_ff.qual);
   assign srt_wr_en = ((state_ff == ST_SORT_PRV) && (j_ff == '0)) || (state_ff == ST_SORT_CMP);
   assign srt_wr_data = ((state_ff == ST_SORT_CMP) && cur_ahead) ? srt_rd_ff : cur_rec;
   assign srt_rd_en = ((state_ff == ST_SORT_PRV) && (j_ff != '0)) || (state_ff == ST_PICK_RD);
   assign srt_raddr = (state_ff == ST_PICK_RD) ? TB'(pos_ff) : TB'(j_ff - CB'(1));
   always_ff @(posedge clock) begin
      if (srt_wr_en) begin
         srt_mem[TB'(j_ff)] <= srt_wr_data;
      end
      if (srt_rd_en) begin
         srt_rd_ff <= srt_mem[srt_raddr];
      end
   end

   // Key RAM: written in the update cycle, read during check and claim.
   logic [KA-1:0] wr_addr;
   assign key_rd_en = (state_ff == ST_CHK_RD) || (state_ff == ST_CLAIM_RD);
   assign key_addr = KA'(32'(tr_ff) * MAX_HITS_PER_TRACK + 32'(h_ff));
   assign wr_addr = KA'(32'(bt_track_ff) * MAX_HITS_PER_TRACK + 32'(upd_cnt));
   always_ff @(posedge clock) begin
      if (upd_store) begin
         keys_mem[wr_addr] <= bt_key_ff;
      end
      if (key_rd_en) begin
         key_rd_ff <= keys_mem[key_addr];
      end
   end

   assign cl_wr_en = (state_ff == ST_SWEEP) || (state_ff == ST_CLAIM);
   assign cl_wr_key = (state_ff == ST_SWEEP) ? sweep_ff : key_rd_ff;
   assign cl_wr_epoch = (state_ff == ST_SWEEP) ? '0 : epoch_ff;

   tshs_claim_store #(.KEY_BITS(KB), .EPOCH_BITS(EB)) u_claim (
      .clock(clock), .rd_en(state_ff == ST_CHK_WAIT), .rd_key(key_rd_ff),
      .rd_epoch(claim_epoch), .wr_en(cl_wr_en), .wr_key(cl_wr_key),
      .wr_epoch(cl_wr_epoch)
   );

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {1'b0, rej_ff, TRACK_BITS'(tr_ff)};
   assign rsp_tlast = (pos_ff == loaded_ff - CB'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         limit_ff <= '0;
         seen_ff <= '0;
         loaded_ff <= '0;
         epoch_ff <= EB'(1);
         sweep_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_SWEEP: begin
               sweep_ff <= sweep_ff + KB'(1);
               if (sweep_ff == '1) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // Hold the beat; its track record is being read at this edge.
               if (load_go) begin
                  bt_track_ff <= in_t;
                  bt_key_ff <= in_key;
                  bt_qual_ff <= req_tuser[QUAL_BITS+1:2];
                  bt_bad_ff <= req_tuser[QUAL_BITS+2];
                  bt_ok_ff <= in_ok;
                  bt_last_ff <= req_tlast;
                  state_ff <= ST_LD_UPD;
               end
            end
            ST_LD_UPD: begin
               if (upd_first) begin
                  seen_ff[bt_track_ff] <= 1'b1;
                  loaded_ff <= loaded_ff + CB'(1);
               end
               if (bt_last_ff) begin
                  i_ff <= '0;
                  state_ff <= ST_SORT_RD;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_SORT_RD: begin
               if (i_ff >= loaded_ff) begin
                  pos_ff <= '0;
                  state_ff <= (loaded_ff == '0) ? ST_CLEAR : ST_PICK_RD;
               end else begin
                  state_ff <= ST_SORT_TRK;
               end
            end
            ST_SORT_TRK: begin
               j_ff <= i_ff;
               state_ff <= ST_SORT_PRV;
            end
            ST_SORT_PRV: begin
               // At the head of the list the track is written in place.
               if (j_ff == '0) begin
                  i_ff <= i_ff + CB'(1);
                  state_ff <= ST_SORT_RD;
               end else begin
                  state_ff <= ST_SORT_CMP;
               end
            end
            ST_SORT_CMP: begin
               if (cur_ahead) begin
                  j_ff <= j_ff - CB'(1);
                  state_ff <= ST_SORT_PRV;
               end else begin
                  i_ff <= i_ff + CB'(1);
                  state_ff <= ST_SORT_RD;
               end
            end
            ST_PICK_RD: state_ff <= ST_PICK;
            ST_PICK: begin
               tr_ff <= srt_rd_ff.track;
               wk_cnt_ff <= srt_rd_ff.cnt;
               rej_ff <= srt_rd_ff.bad;
               h_ff <= '0;
               shared_ff <= '0;
               if (srt_rd_ff.bad) state_ff <= ST_OUT;
               else state_ff <= ST_CHK_RD;
            end
            ST_CHK_RD: begin
               if (h_ff == wk_cnt_ff) begin
                  h_ff <= '0;
                  state_ff <= ST_CLAIM_RD;
               end else begin
                  state_ff <= ST_CHK_WAIT;
               end
            end
            ST_CHK_WAIT: state_ff <= ST_CHK;
            ST_CHK: begin
               h_ff <= h_ff + HB'(1);
               state_ff <= ST_CHK_RD;
               // A hit is claimed when its store entry carries this event's epoch.
               if (claim_epoch == epoch_ff) begin
                  shared_ff <= shared_ff + HB'(1);
                  if (7'(shared_ff) + 7'd1 > 7'(limit_ff)) begin
                     rej_ff <= 1'b1;
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_CLAIM_RD: begin
               if (h_ff == wk_cnt_ff) state_ff <= ST_OUT;
               else state_ff <= ST_CLAIM;
            end
            ST_CLAIM: begin
               h_ff <= h_ff + HB'(1);
               state_ff <= ST_CLAIM_RD;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  pos_ff <= pos_ff + CB'(1);
                  state_ff <= rsp_tlast ? ST_CLEAR : ST_PICK_RD;
               end
            end
            ST_CLEAR: begin
               seen_ff <= '0;
               loaded_ff <= '0;
               // Advance the epoch; on wrap, sweep the store back to zero.
               if (epoch_ff == '1) begin
                  epoch_ff <= EB'(1);
                  sweep_ff <= '0;
                  state_ff <= ST_SWEEP;
               end else begin
                  epoch_ff <= epoch_ff + EB'(1);
                  state_ff <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   `TSHS_ASSERT_NEVER(a_ready_out, clock, reset, req_tready && rsp_tvalid,
      "input accepted while a decision is pending")
   `TSHS_ASSERT_NEVER(a_epoch_zero, clock, reset, epoch_ff == '0,
      "epoch zero is reserved for cleared entries")
   `TSHS_ASSERT_IMPL(a_out_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "decision changed while stalled")
endmodule
